@@ src/tsup_pkg.sv @@
// Shared types and constants of the shortest-unique-prefix tree.
// Used by the top level and its checker; depends on nothing.
package tsup_pkg;

  localparam int NODE_COUNT    = 4096;
  localparam int ALPHABET_SIZE = 32;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int FREE_W = NODE_W + 1;
  localparam int SYM_W  = $clog2(ALPHABET_SIZE);
  localparam int ROW_W  = ALPHABET_SIZE * NODE_W;
  localparam int PASS_W = 16;
  localparam int LEN_W  = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POOL_FULL = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] symbol;
    logic       last_symbol;
  } item_t;

  typedef struct packed {
    logic [7:0] prefix_length;
    logic [1:0] status;
  } result_t;

endpackage

@@ src/tsup_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds until the next read. No package dependency.
module tsup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

@@ src/trie_shortest_unique_prefix.sv @@
// Shortest-unique-prefix tree: node row memory, pass count memory, walk sequencer.
// Depends on tsup_pkg and tsup_ram.
//
//  channel  | handshake              | word     | taken when
//  ---------+------------------------+----------+--------------------------
//  item     | start / busy           | item_t   | start && !busy at clk edge
//  result   | result_valid (strobe)  | result_t | every cycle result_valid=1
//
// An insert or query symbol keeps busy high through child row read, pass count
// read or node link, and finish. A missing child that stops the walk (query
// path not found, pool full) goes from the row read straight to finish. A word
// whose walk has already stopped, or a query on a node only one word passes,
// goes straight to finish. Clear and unknown operations do not raise busy.
// The result strobe follows the finish cycle of the word's last symbol.
// A node row holds all children of a node, so an allocation clears a row in
// one write. Reset is synchronous; the memories need no clearing pass.
// The receiver cannot stall: a result is shown for exactly one cycle.
module trie_shortest_unique_prefix
  import tsup_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    result_valid,
  output result_t result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_IP   = 3'd2;
  localparam logic [2:0] S_QP   = 3'd3;
  localparam logic [2:0] S_LINK = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]             state;
  logic [1:0]             op_q;
  logic [SYM_W-1:0]       sym_q;
  logic                   last_q;
  logic [ALPHABET_SIZE-1:0] root_valid;
  logic [FREE_W-1:0]      free_node;
  logic [NODE_W-1:0]      walk_node;
  logic [PASS_W-1:0]      walk_pass;
  logic [LEN_W-1:0]       consumed;
  logic                   walk_stopped;
  logic [1:0]             word_error;

  logic                   child_we, child_re, pass_we, pass_re;
  logic [NODE_W-1:0]      child_wa, child_ra, pass_wa, pass_ra;
  logic [ROW_W-1:0]       child_wd, rd_row, row_mod;
  logic [PASS_W-1:0]      pass_wd, pass_q, pass_inc;

  logic                   accept;
  logic [SYM_W-1:0]       in_sym;
  logic [NODE_W-1:0]      child;
  logic                   child_exists;
  logic                   pool_full;
  logic [LEN_W-1:0]       consumed_inc;

  tsup_ram #(.WIDTH(ROW_W), .DEPTH(NODE_COUNT)) u_child_ram (
    .clk(clk), .we(child_we), .wa(child_wa), .wd(child_wd),
    .re(child_re), .ra(child_ra), .rd(rd_row)
  );

  tsup_ram #(.WIDTH(PASS_W), .DEPTH(NODE_COUNT)) u_pass_ram (
    .clk(clk), .we(pass_we), .wa(pass_wa), .wd(pass_wd),
    .re(pass_re), .ra(pass_ra), .rd(pass_q)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign in_sym = item.symbol[SYM_W-1:0];

  assign child        = rd_row[sym_q*NODE_W +: NODE_W];
  // root row is never cleared, so its entries go through the valid bits
  assign child_exists = (walk_node == '0) ? root_valid[sym_q] : (child != '0);
  assign pool_full    = free_node[NODE_W];
  assign consumed_inc = (consumed == '1) ? consumed : consumed + LEN_W'(1);
  assign pass_inc     = (pass_q == '1) ? pass_q : pass_q + PASS_W'(1);

  // parent row with the new child linked in
  always_comb begin
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      row_mod[i*NODE_W +: NODE_W] = (SYM_W'(i) == sym_q) ? free_node[NODE_W-1:0]
                                                        : rd_row[i*NODE_W +: NODE_W];
    end
  end

  always_comb begin
    child_re = 1'b0;
    child_ra = walk_node;
    child_we = 1'b0;
    child_wa = walk_node;
    child_wd = row_mod;
    pass_re  = 1'b0;
    pass_ra  = child;
    pass_we  = 1'b0;
    pass_wa  = walk_node;
    pass_wd  = pass_inc;
    case (state)
      S_IDLE: begin
        if (accept && (item.operation == OP_INSERT || item.operation == OP_QUERY) &&
            !walk_stopped &&
            !(item.operation == OP_QUERY && walk_node != '0 && walk_pass == PASS_W'(1))) begin
          child_re = 1'b1;
        end
      end
      S_RD: begin
        if (child_exists) begin
          pass_re = 1'b1;
        end else if (op_q == OP_INSERT && !pool_full) begin
          child_we = 1'b1;
          pass_we  = 1'b1;
          pass_wa  = free_node[NODE_W-1:0];
          pass_wd  = PASS_W'(1);
        end
      end
      S_IP: begin
        pass_we = 1'b1;
      end
      S_LINK: begin
        // walk_node is the new node here: clear its child row
        child_we = 1'b1;
        child_wd = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      root_valid   <= '0;
      free_node    <= FREE_W'(1);
      walk_node    <= '0;
      consumed     <= '0;
      walk_stopped <= 1'b0;
      word_error   <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_FIN) && last_q;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q   <= item.operation;
            sym_q  <= in_sym;
            last_q <= item.last_symbol;
            if (item.operation == OP_CLEAR) begin
              root_valid   <= '0;
              free_node    <= FREE_W'(1);
              walk_node    <= '0;
              consumed     <= '0;
              walk_stopped <= 1'b0;
              word_error   <= ST_OK;
            end else if (item.operation == OP_INSERT || item.operation == OP_QUERY) begin
              if (walk_stopped) begin
                state <= S_FIN;
              end else if (item.operation == OP_QUERY && walk_node != '0 &&
                           walk_pass == PASS_W'(1)) begin
                walk_stopped <= 1'b1;
                state        <= S_FIN;
              end else begin
                state <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          if (child_exists) begin
            walk_node <= child;
            consumed  <= consumed_inc;
            state     <= (op_q == OP_INSERT) ? S_IP : S_QP;
          end else if (op_q == OP_QUERY) begin
            word_error   <= ST_NOT_FOUND;
            walk_stopped <= 1'b1;
            state        <= S_FIN;
          end else if (pool_full) begin
            word_error   <= ST_POOL_FULL;
            walk_stopped <= 1'b1;
            state        <= S_FIN;
          end else begin
            if (walk_node == '0) begin
              root_valid[sym_q] <= 1'b1;
            end
            walk_node <= free_node[NODE_W-1:0];
            walk_pass <= PASS_W'(1);
            free_node <= free_node + FREE_W'(1);
            consumed  <= consumed_inc;
            state     <= S_LINK;
          end
        end
        S_IP: begin
          walk_pass <= pass_inc;
          state     <= S_FIN;
        end
        S_QP: begin
          walk_pass <= pass_q;
          state     <= S_FIN;
        end
        S_LINK: begin
          state <= S_FIN;
        end
        S_FIN: begin
          state <= S_IDLE;
          if (last_q) begin
            result.prefix_length <= (op_q == OP_QUERY) ? consumed : '0;
            result.status        <= word_error;
            walk_node            <= '0;
            consumed             <= '0;
            walk_stopped         <= 1'b0;
            word_error           <= ST_OK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/tsup_checker.sv @@
// Port-level checker for the shortest-unique-prefix tree, bound to the top level.
// Depends on tsup_pkg.
module tsup_checker
  import tsup_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input logic    result_valid,
  input result_t result
);

  // a word is only ever shown once the sequencer is back to idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while busy");

  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("results on back-to-back cycles");

  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.operation == OP_INSERT || item.operation == OP_QUERY))
      |=> busy)
    else $error("insert or query symbol did not start a walk");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.operation == OP_CLEAR) |=> (!busy && !result_valid))
    else $error("clear caused work or a result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == ST_OK || result.status == ST_POOL_FULL ||
                      result.status == ST_NOT_FOUND))
    else $error("result carries an undefined status");

endmodule

bind trie_shortest_unique_prefix tsup_checker u_tsup_checker (.*);
